### design/ftn_pkg.sv
// Shared package for the field line tangent unit: codes, state encoding,
// body record and unit request/status structs. No dependencies.
package ftn_pkg;

	localparam int MAX_BODIES_DEF = 64;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EVAL  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// field modes
	localparam logic [2:0] MODE_GRAV  = 3'd0;
	localparam logic [2:0] MODE_ESTAT = 3'd1;
	localparam logic [2:0] MODE_ELEC  = 3'd2;
	localparam logic [2:0] MODE_MAG   = 3'd3;

	// register indexes
	localparam logic [2:0] CFG_MODE   = 3'd0;
	localparam logic [2:0] CFG_GRAV   = 3'd1;
	localparam logic [2:0] CFG_ELIN   = 3'd2;
	localparam logic [2:0] CFG_EQUAD  = 3'd3;
	localparam logic [2:0] CFG_ECUBIC = 3'd4;
	localparam logic [2:0] CFG_MAGX   = 3'd5;
	localparam logic [2:0] CFG_MAGY   = 3'd6;
	localparam logic [2:0] CFG_MAGZ   = 3'd7;

	// per-body field magnitude cap, 2^47 - 1
	localparam logic [46:0] MAG_CAP = '1;

	// divider iteration counts (quotient bits produced)
	localparam logic [6:0] DIV_BITS_GRAV = 7'd48;
	localparam logic [6:0] DIV_BITS_MAG  = 7'd47;
	localparam logic [6:0] DIV_BITS_UNIT = 7'd47;
	localparam logic [6:0] DIV_BITS_NORM = 7'd61;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [30:0]        inv_mass;
		logic signed [31:0] charge;
	} body_t;

	typedef struct packed {
		logic        start;
		logic [64:0] rem0;
		logic [63:0] num;
		logic [63:0] den;
		logic [6:0]  iters;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PM, S_PA, S_RD, S_LD, S_WDIV, S_R2, S_R2CHK, S_SQRT, S_MDIV,
		S_UM, S_UMW, S_TM, S_NEXT, S_FIN, S_NLD, S_NSH, S_NSQ, S_NSQS, S_NSQRT,
		S_NDIV, S_NDIVW, S_NEND, S_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		else if (v < -64'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

endpackage

### design/ftn_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on nothing but the clock.
module ftn_mul (
	input  logic        clk,
	input  logic [47:0] a,
	input  logic [31:0] b,
	output logic [79:0] p
);
	logic [79:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 80'(a) * 80'(b);
	end

	assign p = p_q;
endmodule

### design/ftn_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses ftn_pkg for the request and status structs.
module ftn_div
	import ftn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  div_req_t   req,
	output unit_stat_t stat,
	output logic [63:0] q
);
	logic        busy_q, done_q;
	logic [6:0]  cnt_q;
	logic [64:0] rem_q;
	logic [63:0] num_q, den_q, q_q;
	logic [64:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q[63:0], num_q[63]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= req.rem0;
			num_q <= req.num;
			den_q <= req.den;
			q_q   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			q_q   <= {q_q[62:0], ge};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign q    = q_q;
endmodule

### design/ftn_sqrt.sv
// Iterative integer square root, floor(sqrt(v)) of 64 bits in 32 steps.
// Uses ftn_pkg for the status struct.
module ftn_sqrt
	import ftn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] v,
	output unit_stat_t  stat,
	output logic [31:0] r
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [63:0] v_q, r_q, b_q, t;

	assign t = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			v_q <= v;
			r_q <= '0;
			b_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign r    = r_q[31:0];
endmodule

### design/ftn_store.sv
// Body table: synchronous memory with a registered read, plus
// per-entry valid flags cleared by reset or a clear request. Uses ftn_pkg.
module ftn_store
	import ftn_pkg::*;
#(
	parameter int MAX_BODIES = MAX_BODIES_DEF,
	localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  body_t         wr_data,
	input  logic          clr,
	input  logic [AW-1:0] rd_addr,
	output body_t         rd_data,
	output logic          rd_valid
);
	body_t                 mem_q [MAX_BODIES];
	logic [MAX_BODIES-1:0] valid_q;
	body_t                 rd_data_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr) valid_q <= '0;
			else if (wr_en) valid_q[wr_addr] <= 1'b1;
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;
endmodule

### design/field_line_tangent_nbody.sv
// Write and clear requests are carried out in the idle state as they are accepted.
// An evaluate runs the external polynomial first in electric mode, walks the table
// past empty or skipped entries, and normalizes the sum (twice on a hit).
// The single bit-serial divider serves every division; one item is worked at a time.
// Reset (arst_n low) clears the configuration registers to 0, mode gravitational, table empty.
module field_line_tangent_nbody
	import ftn_pkg::*;
#(
	parameter int MAX_BODIES = MAX_BODIES_DEF,
	localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [5:0]         body_index,
	input  logic signed [31:0] body_px,
	input  logic signed [31:0] body_py,
	input  logic signed [31:0] body_pz,
	input  logic [30:0]        body_inv_mass,
	input  logic signed [31:0] body_charge,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] tangent_x,
	output logic signed [31:0] tangent_y,
	output logic signed [31:0] tangent_z,
	output logic               hit_body,
	// register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_BODIES - 1);

	// ---------------- configuration registers ----------------
	logic [2:0]         field_mode_q;
	logic signed [31:0] grav_q, elin_q, equad_q, ecubic_q, magx_q, magy_q, magz_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_mode_q <= MODE_GRAV;
			grav_q   <= '0;
			elin_q   <= '0;
			equad_q  <= '0;
			ecubic_q <= '0;
			magx_q   <= '0;
			magy_q   <= '0;
			magz_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:   field_mode_q <= cfg_data[2:0];
				CFG_GRAV:   grav_q   <= cfg_data;
				CFG_ELIN:   elin_q   <= cfg_data;
				CFG_EQUAD:  equad_q  <= cfg_data;
				CFG_ECUBIC: ecubic_q <= cfg_data;
				CFG_MAGX:   magx_q   <= cfg_data;
				CFG_MAGY:   magy_q   <= cfg_data;
				CFG_MAGZ:   magz_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- units ----------------
	state_t state_q, state_d;

	logic          st_wr_en, st_clr, st_rd_valid;
	body_t         st_wr_data, st_rd;
	logic [AW-1:0] idx_q;

	div_req_t    div_req;
	unit_stat_t  div_st, sq_st;
	logic [63:0] div_q;
	logic        sq_start;
	logic [31:0] sq_r;
	logic [47:0] mul_a;
	logic [31:0] mul_b;
	logic [79:0] mul_p;
	logic [63:0] sum_q;     // r^2 of a body, later sum of squares in normalize

	// Table writes go straight to memory; the sequencer reads entry idx_q each cycle.
	assign st_wr_data = '{px: body_px, py: body_py, pz: body_pz,
		inv_mass: body_inv_mass, charge: body_charge};

	ftn_store #(.MAX_BODIES(MAX_BODIES)) u_store (
		.clk, .arst_n,
		.wr_en(st_wr_en), .wr_addr(AW'(body_index)), .wr_data(st_wr_data),
		.clr(st_clr), .rd_addr(idx_q), .rd_data(st_rd), .rd_valid(st_rd_valid)
	);

	ftn_div  u_div  (.clk, .arst_n, .req(div_req), .stat(div_st), .q(div_q));
	ftn_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .v(sum_q), .stat(sq_st), .r(sq_r));
	ftn_mul  u_mul  (.clk, .a(mul_a), .b(mul_b), .p(mul_p));

	// ---------------- datapath registers ----------------
	logic signed [31:0] pt_q   [3];
	logic signed [63:0] ext_q  [3];
	logic signed [63:0] bacc_q [3];
	logic [31:0]        relmag_q [3];
	logic [2:0]         relneg_q;
	logic [31:0]        wm_q;
	logic               wneg_q;
	logic [31:0]        r_q;
	logic [46:0]        m_q;
	logic signed [31:0] h_q;
	logic               psign_q;
	logic signed [63:0] nv_q   [3];  // vector being normalized
	logic [63:0]        nm_q   [3];
	logic [2:0]         nneg_q;
	logic [63:0]        nmx_q;
	logic [31:0]        n_q;
	logic signed [31:0] nres_q [3];
	logic               hit_q, pass_q;  // pass_q: 0 while normalizing the partial sum on a hit
	logic [1:0]         cnt_q;
	logic               out_valid_q, hit_body_q;
	logic signed [31:0] tang_q [3];

	// ---------------- combinational helpers ----------------
	logic               idx_ok, body_loop, skip;
	logic signed [31:0] pos_c [3];
	logic signed [63:0] diff_c [3];
	logic signed [31:0] rel_c [3];
	logic [31:0]        rel_abs_c [3];
	logic [63:0]        nabs_c [3];
	logic [63:0]        nmx_c;
	logic [31:0]        relmag_sel;
	logic [63:0]        nm_sel;
	logic               nneg_sel, relneg_sel;
	logic signed [31:0] hsel, addend, hm;
	logic signed [63:0] pm_s, tm_s;
	logic [63:0]        wcap, wm2;

	assign idx_ok    = 32'(body_index) < MAX_BODIES;
	// bodies contribute only in gravity (with nonzero coupling), electrostatic, electric
	assign body_loop = (field_mode_q == MODE_GRAV && grav_q != 0) ||
		field_mode_q == MODE_ESTAT || field_mode_q == MODE_ELEC;
	assign skip      = (field_mode_q == MODE_GRAV) ? (st_rd.inv_mass == '0) :
		(st_rd.charge == '0);
	assign wm2       = 64'({wm_q, 1'b0});
	// gravity weight magnitude limit: -2^31 allowed when the weight is negative
	assign wcap      = wneg_q ? 64'h8000_0000 : 64'h7fff_ffff;
	assign hsel      = (cnt_q == 2'd0) ? ecubic_q : h_q;
	assign addend    = (cnt_q == 2'd0) ? equad_q : elin_q;
	assign pm_s      = psign_q ? -$signed({16'b0, mul_p[63:16]}) : $signed({16'b0, mul_p[63:16]});
	assign hm        = sat32(pm_s);
	assign tm_s      = $signed({16'b0, mul_p[62:15]});

	always_comb begin
		pos_c[0] = st_rd.px;
		pos_c[1] = st_rd.py;
		pos_c[2] = st_rd.pz;
		for (int c = 0; c < 3; c++) begin
			diff_c[c]    = 64'(pt_q[c]) - 64'(pos_c[c]);
			rel_c[c]     = sat32(diff_c[c]);
			rel_abs_c[c] = abs32(rel_c[c]);
			nabs_c[c]    = abs64(nv_q[c]);
		end
		nmx_c = nabs_c[0];
		if (nabs_c[1] > nmx_c) nmx_c = nabs_c[1];
		if (nabs_c[2] > nmx_c) nmx_c = nabs_c[2];
	end

	always_comb begin
		case (cnt_q)
			2'd0: begin
				relmag_sel = relmag_q[0]; nm_sel = nm_q[0];
				relneg_sel = relneg_q[0]; nneg_sel = nneg_q[0];
			end
			2'd1: begin
				relmag_sel = relmag_q[1]; nm_sel = nm_q[1];
				relneg_sel = relneg_q[1]; nneg_sel = nneg_q[1];
			end
			2'd2: begin
				relmag_sel = relmag_q[2]; nm_sel = nm_q[2];
				relneg_sel = relneg_q[2]; nneg_sel = nneg_q[2];
			end
			default: begin
				relmag_sel = '0; nm_sel = '0;
				relneg_sel = 1'b0; nneg_sel = 1'b0;
			end
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		st_wr_en = 1'b0;
		st_clr   = 1'b0;
		div_req  = '0;
		sq_start = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (req_type)
						REQ_WRITE: st_wr_en = idx_ok;
						REQ_CLEAR: st_clr = 1'b1;
						REQ_EVAL: begin
							if (field_mode_q == MODE_ELEC) state_d = S_PM;
							else if (body_loop) state_d = S_RD;
							else state_d = S_FIN;
						end
						default: ;
					endcase
				end
			end
			// external polynomial, Horner with one multiply per step
			S_PM: begin
				mul_a   = 48'(abs32(hsel));
				mul_b   = abs32(pt_q[0]);
				state_d = S_PA;
			end
			S_PA: state_d = (cnt_q == 2'd2) ? S_RD : S_PM;
			// body walk
			S_RD: state_d = S_LD;
			S_LD: begin
				if (!st_rd_valid || skip) begin
					state_d = S_NEXT;
				end else if (field_mode_q == MODE_GRAV) begin
					div_req.start = 1'b1;
					div_req.num   = {abs32(grav_q), 32'b0};
					div_req.den   = 64'(st_rd.inv_mass);
					div_req.iters = DIV_BITS_GRAV;
					state_d       = S_WDIV;
				end else begin
					state_d = S_R2;
				end
			end
			S_WDIV: if (div_st.done) state_d = S_R2;
			S_R2: begin
				mul_a = 48'(relmag_sel);
				mul_b = relmag_sel;
				if (cnt_q == 2'd3) state_d = S_R2CHK;
			end
			S_R2CHK: begin
				if (sum_q == '0) begin
					state_d = S_NLD;
				end else begin
					sq_start = 1'b1;
					state_d  = S_SQRT;
				end
			end
			S_SQRT: begin
				if (sq_st.done) begin
					if (wm2 >= sum_q) begin
						state_d = S_UM;
					end else begin
						div_req.start = 1'b1;
						div_req.rem0  = 65'(wm2);
						div_req.den   = sum_q;
						div_req.iters = DIV_BITS_MAG;
						state_d       = S_MDIV;
					end
				end
			end
			S_MDIV: if (div_st.done) state_d = S_UM;
			S_UM: begin
				div_req.start = 1'b1;
				div_req.num   = {relmag_sel, 32'b0};
				div_req.den   = 64'(r_q);
				div_req.iters = DIV_BITS_UNIT;
				state_d       = S_UMW;
			end
			S_UMW: begin
				if (div_st.done) begin
					mul_a   = 48'(m_q);
					mul_b   = 32'(div_q[15:0]);
					state_d = S_TM;
				end
			end
			S_TM:   state_d = (cnt_q == 2'd2) ? S_NEXT : S_UM;
			S_NEXT: state_d = (idx_q == LAST_IDX) ? S_FIN : S_RD;
			S_FIN:  state_d = S_NLD;
			// normalize nv_q into nres_q
			S_NLD:  state_d = (nmx_c == '0) ? S_NEND : S_NSH;
			S_NSH: begin
				if (nmx_q[63:31] == '0 && nmx_q[30]) state_d = S_NSQ;
			end
			S_NSQ: begin
				mul_a = 48'(nm_sel[31:0]);
				mul_b = nm_sel[31:0];
				if (cnt_q == 2'd3) state_d = S_NSQS;
			end
			S_NSQS: begin
				sq_start = 1'b1;
				state_d  = S_NSQRT;
			end
			S_NSQRT: if (sq_st.done) state_d = S_NDIV;
			S_NDIV: begin
				div_req.start = 1'b1;
				div_req.num   = {nm_sel[30:0], 33'b0};
				div_req.den   = 64'(n_q);
				div_req.iters = DIV_BITS_NORM;
				state_d       = S_NDIVW;
			end
			S_NDIVW: if (div_st.done) state_d = (cnt_q == 2'd2) ? S_NEND : S_NDIV;
			S_NEND:  state_d = pass_q ? S_DONE : S_NLD;
			S_DONE:  if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			pass_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					idx_q <= '0;
					hit_q <= 1'b0;
				end
				S_PA, S_TM:   cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
				S_R2, S_NSQ:  cnt_q <= cnt_q + 2'd1;
				S_NDIVW: if (div_st.done) cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
				S_NEXT:  if (idx_q != LAST_IDX) idx_q <= idx_q + 1'b1;
				S_R2CHK: begin
					if (sum_q == '0) begin
						hit_q  <= 1'b1;
						pass_q <= 1'b0;
					end
				end
				S_FIN:  pass_q <= 1'b1;
				S_NEND: pass_q <= 1'b1;
				default: ;
			endcase
			if (state_q == S_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pt_q[0] <= point_x;
				pt_q[1] <= point_y;
				pt_q[2] <= point_z;
				for (int c = 0; c < 3; c++) bacc_q[c] <= '0;
				if (field_mode_q == MODE_MAG) begin
					ext_q[0] <= 64'(magx_q) <<< 16;
					ext_q[1] <= 64'(magy_q) <<< 16;
					ext_q[2] <= 64'(magz_q) <<< 16;
				end else begin
					for (int c = 0; c < 3; c++) ext_q[c] <= '0;
				end
			end
			S_PM: psign_q <= hsel[31] ^ pt_q[0][31];
			S_PA: begin
				if (cnt_q == 2'd2) ext_q[0] <= 64'(hm) <<< 16;
				else h_q <= sat32(64'(addend) + 64'(hm));
			end
			S_LD: begin
				for (int c = 0; c < 3; c++) begin
					relmag_q[c] <= rel_abs_c[c];
					relneg_q[c] <= rel_c[c][31];
				end
				sum_q <= '0;
				if (field_mode_q == MODE_GRAV) wneg_q <= !grav_q[31];
				else begin
					wm_q   <= abs32(st_rd.charge);
					wneg_q <= st_rd.charge[31];
				end
			end
			S_WDIV: if (div_st.done) wm_q <= (div_q > wcap) ? wcap[31:0] : div_q[31:0];
			S_R2, S_NSQ: if (cnt_q != 2'd0) sum_q <= sum_q + mul_p[63:0];
			S_R2CHK: if (sum_q == '0) for (int c = 0; c < 3; c++) nv_q[c] <= bacc_q[c];
			S_SQRT: begin
				if (sq_st.done) begin
					r_q <= sq_r;
					if (wm2 >= sum_q) m_q <= MAG_CAP;
				end
			end
			S_MDIV: if (div_st.done) m_q <= div_q[46:0];
			S_TM: begin
				for (int c = 0; c < 3; c++) begin
					if (cnt_q == 2'(c)) begin
						if (wneg_q != relneg_sel) bacc_q[c] <= bacc_q[c] - tm_s;
						else bacc_q[c] <= bacc_q[c] + tm_s;
					end
				end
			end
			S_FIN: for (int c = 0; c < 3; c++) nv_q[c] <= ext_q[c] + bacc_q[c];
			S_NLD: begin
				for (int c = 0; c < 3; c++) begin
					nm_q[c]   <= nabs_c[c];
					nneg_q[c] <= nv_q[c][63];
					nres_q[c] <= '0;
				end
				nmx_q <= nmx_c;
			end
			// one bit per cycle until the largest magnitude sits in [2^30, 2^31)
			S_NSH: begin
				if (nmx_q[63:31] != '0) begin
					nmx_q <= nmx_q >> 1;
					for (int c = 0; c < 3; c++) nm_q[c] <= nm_q[c] >> 1;
				end else if (!nmx_q[30]) begin
					nmx_q <= nmx_q << 1;
					for (int c = 0; c < 3; c++) nm_q[c] <= nm_q[c] << 1;
				end else begin
					sum_q <= '0;
				end
			end
			S_NSQRT: if (sq_st.done) n_q <= sq_r;
			S_NDIVW: begin
				if (div_st.done) begin
					for (int c = 0; c < 3; c++) begin
						if (cnt_q == 2'(c))
							nres_q[c] <= nneg_sel ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
					end
				end
			end
			// hit: unit partial sum scaled to Q32.32, then external field added
			S_NEND: begin
				if (!pass_q)
					for (int c = 0; c < 3; c++) nv_q[c] <= ext_q[c] + (64'(nres_q[c]) <<< 2);
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					for (int c = 0; c < 3; c++) tang_q[c] <= nres_q[c];
					hit_body_q <= hit_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign tangent_x = tang_q[0];
	assign tangent_y = tang_q[1];
	assign tangent_z = tang_q[2];
	assign hit_body  = hit_body_q;

	// ---------------- assertions ----------------
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_st.busy) else $error("divider started while busy");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_st.busy && !sq_st.busy) else $error("unit busy while idle");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tangent_x <= 32'sd1073741824 && tangent_x >= -32'sd1073741824 &&
		tangent_y <= 32'sd1073741824 && tangent_y >= -32'sd1073741824 &&
		tangent_z <= 32'sd1073741824 && tangent_z >= -32'sd1073741824)
		else $error("tangent component beyond unit range");

	a_hit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_body |-> field_mode_q == MODE_GRAV ||
		field_mode_q == MODE_ESTAT || field_mode_q == MODE_ELEC)
		else $error("hit flagged in a mode without bodies");

endmodule
